/* hw/rtl/tse_pkg.sv */
package tse_pkg;

	localparam int MAP_ENTRIES_DEF      = 4096;
	localparam int TILE_NUMBER_BITS_DEF = 15;

	localparam int DIV_W = 16;
	localparam int IDX_W = 18;

	localparam logic [2:0] MODE_WRITE    = 3'd0;
	localparam logic [2:0] MODE_READ     = 3'd1;
	localparam logic [2:0] MODE_FILL     = 3'd2;
	localparam logic [2:0] MODE_SCROLL_X = 3'd3;
	localparam logic [2:0] MODE_SCROLL_Y = 3'd4;
	localparam logic [2:0] MODE_SET_POS  = 3'd5;
	localparam logic [2:0] MODE_FETCH    = 3'd6;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_RANGE  = 2'd1;
	localparam logic [1:0] STATUS_OFFSET = 2'd2;

	localparam logic [2:0] REG_MAP_W    = 3'd0;
	localparam logic [2:0] REG_MAP_H    = 3'd1;
	localparam logic [2:0] REG_TILE_W   = 3'd2;
	localparam logic [2:0] REG_TILE_H   = 3'd3;
	localparam logic [2:0] REG_SCREEN_W = 3'd4;
	localparam logic [2:0] REG_SCREEN_H = 3'd5;
	localparam logic [2:0] REG_SHEET    = 3'd6;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0] quo;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage

/* hw/rtl/tse_divider.sv */
module tse_divider
	import tse_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   trial;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.dividend;
				den_q  <= req.divisor;
				cnt_q  <= CW'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!trial[DIV_W]) begin
					rem_q <= trial[DIV_W-1:0];
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[DIV_W-1:0];
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

/* hw/rtl/tse_store.sv */
module tse_store #(
	parameter int DEPTH = 4096,
	parameter int DW    = 15
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* hw/rtl/tilemap_scroll_engine.sv */
// Tile map layer with scroll position. One request is worked at a time and gives one result.
// After reset the store is cleared before the first request is taken. A fill sweeps the
// store one entry a cycle. A fetch runs up to five divisions, one after another, on one
// shared bit-serial divider. A result waits in the output register while the next request
// is taken.
module tilemap_scroll_engine
	import tse_pkg::*;
#(
	parameter int MAP_ENTRIES      = MAP_ENTRIES_DEF,
	parameter int TILE_NUMBER_BITS = TILE_NUMBER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [7:0]  tile_col,
	input  logic [7:0]  tile_row,
	input  logic [14:0] tile_value,
	input  logic [14:0] scroll_offset,
	input  logic        wrap_enable,
	input  logic [13:0] target_x,
	input  logic [13:0] target_y,
	input  logic [11:0] screen_x,
	input  logic [11:0] screen_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] tile_out,
	output logic [13:0] position_x,
	output logic [13:0] position_y,
	output logic [13:0] sheet_x,
	output logic [13:0] sheet_y,
	output logic        is_empty,
	output logic [1:0]  status
);

	localparam int AW = $clog2(MAP_ENTRIES);
	localparam int TW = TILE_NUMBER_BITS;

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_FILL  = 18'h00002,
		S_RW    = 18'h00004,
		S_RDA   = 18'h00008,
		S_RDB   = 18'h00010,
		S_AXP   = 18'h00020,
		S_AXA   = 18'h00040,
		S_FPREP = 18'h00080,
		S_FXM   = 18'h00100,
		S_FXD   = 18'h00200,
		S_FYM   = 18'h00400,
		S_FYD   = 18'h00800,
		S_FIDX  = 18'h01000,
		S_FRDA  = 18'h02000,
		S_FRDB  = 18'h04000,
		S_FTDIV = 18'h08000,
		S_FMUL  = 18'h10000,
		S_DONE  = 18'h20000
	} state_t;

	state_t state_q;

	logic [8:0] mw_q, mh_q, sw_q, sh_q, spr_q;
	logic [6:0] tw_q, th_q;

	logic [2:0]  mode_q;
	logic [7:0]  col_q, row_q;
	logic [TW-1:0] val_q;
	logic [14:0] off_in_q;
	logic        wrap_q;
	logic [13:0] tx_q, ty_q;
	logic [11:0] scx_q, scy_q;
	logic [13:0] pos_x_q, pos_y_q;

	logic [AW-1:0] addr_q;
	logic          clear_q;
	logic          issued_q;
	logic          axis_q;
	logic [14:0]   off_q;
	logic [15:0]   ext_q, limit_q;
	logic [15:0]   pw_q, ph_q;
	logic [14:0]   px_q, py_q;
	logic [15:0]   tmp_q;
	logic [8:0]    mx_q, my_q;
	logic [6:0]    finex_q, finey_q;
	logic [TW-1:0] t_q;

	logic [14:0] tile_q;
	logic [13:0] shx_q, shy_q;
	logic        empty_q;
	logic [1:0]  status_q;

	logic        out_valid_q;
	logic [14:0] o_tile_q;
	logic [13:0] o_px_q, o_py_q, o_shx_q, o_shy_q;
	logic        o_empty_q;
	logic [1:0]  o_status_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [TW-1:0] wr_data;
	logic [TW-1:0] rd_data;

	logic [IDX_W-1:0] rw_idx, f_idx;
	logic             rw_oob;

	logic [8:0]  ax_mt, ax_st;
	logic [6:0]  ax_tp;
	logic [13:0] ax_pos, ax_tgt, ax_new;
	logic [14:0] ax_off;
	logic        ax_rej, ax_wrap;
	logic signed [17:0] sp, so, se, sl, ss, smag, sres;

	tse_store #(
		.DEPTH(MAP_ENTRIES),
		.DW   (TW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	tse_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	assign rw_idx = IDX_W'(row_q) * IDX_W'(mw_q) + IDX_W'(col_q);
	assign rw_oob = ({1'b0, col_q} >= mw_q) || ({1'b0, row_q} >= mh_q)
		|| (rw_idx >= IDX_W'(MAP_ENTRIES));
	assign f_idx  = IDX_W'(my_q) * IDX_W'(mw_q) + IDX_W'(mx_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rw_idx[AW-1:0];
		wr_data = val_q;
		if (state_q == S_FILL) begin
			wr_en   = 1'b1;
			wr_addr = addr_q;
			wr_data = clear_q ? '0 : val_q;
		end else if (state_q == S_RW && mode_q == MODE_WRITE && !rw_oob) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		unique case (state_q)
			S_FXM: begin
				div_req.dividend = {1'b0, px_q};
				div_req.divisor  = pw_q;
				div_req.start    = !issued_q && pw_q != '0 && ph_q != '0;
			end
			S_FXD: begin
				div_req.dividend = tmp_q;
				div_req.divisor  = DIV_W'(tw_q);
				div_req.start    = !issued_q;
			end
			S_FYM: begin
				div_req.dividend = {1'b0, py_q};
				div_req.divisor  = ph_q;
				div_req.start    = !issued_q;
			end
			S_FYD: begin
				div_req.dividend = tmp_q;
				div_req.divisor  = DIV_W'(th_q);
				div_req.start    = !issued_q;
			end
			S_FTDIV: begin
				div_req.dividend = DIV_W'(t_q);
				div_req.divisor  = DIV_W'(spr_q);
				div_req.start    = !issued_q;
			end
			default: begin
			end
		endcase
	end

	// per-axis operands
	always_comb begin
		ax_mt   = axis_q ? mh_q : mw_q;
		ax_st   = axis_q ? sh_q : sw_q;
		ax_tp   = axis_q ? th_q : tw_q;
		ax_pos  = axis_q ? pos_y_q : pos_x_q;
		ax_tgt  = axis_q ? ty_q : tx_q;
		ax_wrap = (mode_q == MODE_SET_POS) ? 1'b1 : wrap_q;
		if (mode_q == MODE_SET_POS) begin
			ax_off = {1'b0, ax_tgt} - {1'b0, ax_pos};
		end else begin
			ax_off = off_in_q;
		end
	end

	always_comb begin
		sp   = $signed({4'b0, ax_pos});
		so   = $signed({{3{off_q[14]}}, off_q});
		se   = $signed({2'b0, ext_q});
		sl   = $signed({2'b0, limit_q});
		ss   = sp + so;
		smag = off_q[14] ? -so : so;
		ax_rej = smag > se;
		if (ax_wrap) begin
			if (so > 18'sd0) begin
				sres = (ss < se) ? ss : ss - se;
			end else begin
				sres = (ss >= 18'sd0) ? ss : ss + se;
			end
		end else begin
			if (so > 18'sd0) begin
				sres = (ss > sl) ? sl : ss;
			end else begin
				sres = (ss < 18'sd0) ? 18'sd0 : ss;
			end
		end
		if (sres < 18'sd0) begin
			ax_new = '0;
		end else if (sres > 18'sd16383) begin
			ax_new = 14'h3fff;
		end else begin
			ax_new = sres[13:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			mw_q        <= 9'd64;
			mh_q        <= 9'd64;
			tw_q        <= 7'd16;
			th_q        <= 7'd16;
			sw_q        <= 9'd20;
			sh_q        <= 9'd15;
			spr_q       <= 9'd16;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			addr_q      <= '0;
			clear_q     <= 1'b1;
			issued_q    <= 1'b0;
			axis_q      <= 1'b0;
			mode_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			val_q       <= '0;
			off_in_q    <= '0;
			wrap_q      <= 1'b0;
			tx_q        <= '0;
			ty_q        <= '0;
			scx_q       <= '0;
			scy_q       <= '0;
			off_q       <= '0;
			ext_q       <= '0;
			limit_q     <= '0;
			pw_q        <= '0;
			ph_q        <= '0;
			px_q        <= '0;
			py_q        <= '0;
			tmp_q       <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			finex_q     <= '0;
			finey_q     <= '0;
			t_q         <= '0;
			tile_q      <= '0;
			shx_q       <= '0;
			shy_q       <= '0;
			empty_q     <= 1'b0;
			status_q    <= STATUS_OK;
			out_valid_q <= 1'b0;
			o_tile_q    <= '0;
			o_px_q      <= '0;
			o_py_q      <= '0;
			o_shx_q     <= '0;
			o_shy_q     <= '0;
			o_empty_q   <= 1'b0;
			o_status_q  <= STATUS_OK;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MAP_W:    mw_q  <= cfg_data;
					REG_MAP_H:    mh_q  <= cfg_data;
					REG_TILE_W:   tw_q  <= cfg_data[6:0];
					REG_TILE_H:   th_q  <= cfg_data[6:0];
					REG_SCREEN_W: sw_q  <= cfg_data;
					REG_SCREEN_H: sh_q  <= cfg_data;
					REG_SHEET:    spr_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q   <= mode;
						col_q    <= tile_col;
						row_q    <= tile_row;
						val_q    <= TW'(tile_value);
						off_in_q <= scroll_offset;
						wrap_q   <= wrap_enable;
						tx_q     <= target_x;
						ty_q     <= target_y;
						scx_q    <= screen_x;
						scy_q    <= screen_y;
						tile_q   <= '0;
						shx_q    <= '0;
						shy_q    <= '0;
						empty_q  <= 1'b0;
						status_q <= STATUS_OK;
						addr_q   <= '0;
						issued_q <= 1'b0;
						unique case (mode)
							MODE_WRITE, MODE_READ: state_q <= S_RW;
							MODE_FILL:             state_q <= S_FILL;
							MODE_SCROLL_X, MODE_SET_POS: begin
								axis_q  <= 1'b0;
								state_q <= S_AXP;
							end
							MODE_SCROLL_Y: begin
								axis_q  <= 1'b1;
								state_q <= S_AXP;
							end
							MODE_FETCH:            state_q <= S_FPREP;
							default:               state_q <= S_DONE;
						endcase
					end
				end
				S_FILL: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(MAP_ENTRIES - 1)) begin
						clear_q <= 1'b0;
						state_q <= clear_q ? S_IDLE : S_DONE;
					end
				end
				S_RW: begin
					if (rw_oob) begin
						status_q <= STATUS_RANGE;
						state_q  <= S_DONE;
					end else if (mode_q == MODE_WRITE) begin
						state_q <= S_DONE;
					end else begin
						addr_q  <= rw_idx[AW-1:0];
						state_q <= S_RDA;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					tile_q  <= 15'(rd_data);
					state_q <= S_DONE;
				end
				S_AXP: begin
					ext_q <= 16'(ax_mt) * 16'(ax_tp);
					if (ax_mt > ax_st) begin
						limit_q <= 16'(ax_mt - ax_st) * 16'(ax_tp);
					end else begin
						limit_q <= '0;
					end
					off_q   <= ax_off;
					state_q <= S_AXA;
				end
				S_AXA: begin
					if (ax_rej) begin
						status_q <= STATUS_OFFSET;
					end else if (axis_q) begin
						pos_y_q <= ax_new;
					end else begin
						pos_x_q <= ax_new;
					end
					if (mode_q == MODE_SET_POS && !axis_q) begin
						axis_q  <= 1'b1;
						state_q <= S_AXP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FPREP: begin
					pw_q    <= 16'(mw_q) * 16'(tw_q);
					ph_q    <= 16'(mh_q) * 16'(th_q);
					px_q    <= {1'b0, pos_x_q} + 15'(scx_q);
					py_q    <= {1'b0, pos_y_q} + 15'(scy_q);
					empty_q <= 1'b1;
					state_q <= S_FXM;
				end
				S_FXM: begin
					if (!issued_q) begin
						if (pw_q == '0 || ph_q == '0) begin
							status_q <= STATUS_RANGE;
							state_q  <= S_DONE;
						end else begin
							issued_q <= 1'b1;
						end
					end else if (div_rsp.done) begin
						tmp_q    <= div_rsp.rem;
						issued_q <= 1'b0;
						state_q  <= S_FXD;
					end
				end
				S_FXD: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (div_rsp.done) begin
						mx_q     <= div_rsp.quo[8:0];
						finex_q  <= div_rsp.rem[6:0];
						issued_q <= 1'b0;
						state_q  <= S_FYM;
					end
				end
				S_FYM: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (div_rsp.done) begin
						tmp_q    <= div_rsp.rem;
						issued_q <= 1'b0;
						state_q  <= S_FYD;
					end
				end
				S_FYD: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (div_rsp.done) begin
						my_q     <= div_rsp.quo[8:0];
						finey_q  <= div_rsp.rem[6:0];
						issued_q <= 1'b0;
						state_q  <= S_FIDX;
					end
				end
				S_FIDX: begin
					if (f_idx >= IDX_W'(MAP_ENTRIES)) begin
						status_q <= STATUS_RANGE;
						state_q  <= S_DONE;
					end else begin
						addr_q  <= f_idx[AW-1:0];
						state_q <= S_FRDA;
					end
				end
				S_FRDA: state_q <= S_FRDB;
				S_FRDB: begin
					t_q <= rd_data;
					if (rd_data == '0) begin
						state_q <= S_DONE;
					end else if (spr_q == '0) begin
						status_q <= STATUS_RANGE;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FTDIV;
					end
				end
				S_FTDIV: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (div_rsp.done) begin
						tmp_q    <= div_rsp.quo;
						mx_q     <= div_rsp.rem[8:0];
						issued_q <= 1'b0;
						state_q  <= S_FMUL;
					end
				end
				S_FMUL: begin
					shx_q   <= 14'(mx_q) * 14'(tw_q) + 14'(finex_q);
					shy_q   <= tmp_q[13:0] * 14'(th_q) + 14'(finey_q);
					tile_q  <= 15'(t_q);
					empty_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						o_tile_q    <= tile_q;
						o_px_q      <= pos_x_q;
						o_py_q      <= pos_y_q;
						o_shx_q     <= shx_q;
						o_shy_q     <= shy_q;
						o_empty_q   <= empty_q;
						o_status_q  <= status_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign tile_out   = o_tile_q;
	assign position_x = o_px_q;
	assign position_y = o_py_q;
	assign sheet_x    = o_shx_q;
	assign sheet_y    = o_shy_q;
	assign is_empty   = o_empty_q;
	assign status     = o_status_q;

endmodule
